// File: hdl/vrfc_pkg.sv
// ============================================================================
// vrfc_pkg
// Shared types and constants of the route feasibility and cost block.
// ============================================================================
package vrfc_pkg;

   // Field widths of the transactions.
   localparam int NODE_W   = 6;
   localparam int DIST_W   = 25;
   localparam int COST_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W    = 6;
   localparam int STOPS_W  = 6;

   // Register reset values.
   localparam logic [CSR_W-1:0] CUSTOMER_COUNT_RST = 6'd16;
   localparam logic [CSR_W-1:0] VEHICLE_COUNT_RST  = 6'd4;
   localparam logic [CSR_W-1:0] MAX_STOPS_RST      = 6'd20;

   // Largest value the segment counter holds.
   localparam logic [STOPS_W-1:0] STOPS_MAX = '1;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CUSTOMER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEHICLE_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STOPS      = 2'd2;

   // Request operation codes.
   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_ROUTE_NODE  = 1'b1;

   // Failure reason, lowest nonzero code has priority.
   typedef enum logic [1:0] {
      REASON_NONE     = 2'd0,
      REASON_END_SEP  = 2'd1,
      REASON_ADJ_SEP  = 2'd2,
      REASON_OVERLONG = 2'd3
   } reason_type;

   // Route node handed from the check stage to the cost stage.
   typedef struct packed {
      logic       valid;
      logic       start;
      logic       last;
      logic       oob;
      reason_type reason;
   } leg_type;

endpackage

// File: hdl/vrfc_ifs.sv
// ============================================================================
// vrfc channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ============================================================================
interface vrfc_req_if;
   import vrfc_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [NODE_W-1:0] row;
   logic [NODE_W-1:0] col;
   logic [DIST_W-1:0] distance;
   logic [NODE_W-1:0] node;
   logic              last;

   modport source (output valid, op, row, col, distance, node, last, input ready);
   modport sink   (input valid, op, row, col, distance, node, last, output ready);
endinterface

interface vrfc_rsp_if;
   import vrfc_pkg::*;
   logic              valid;
   logic              ready;
   logic              feasible;
   logic [1:0]        fail_reason;
   logic [COST_W-1:0] route_cost;

   modport source (output valid, feasible, fail_reason, route_cost, input ready);
   modport sink   (input valid, feasible, fail_reason, route_cost, output ready);
endinterface

interface vrfc_csr_if;
   import vrfc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/vrfc_ram.sv
// ============================================================================
// vrfc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ============================================================================
module vrfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port; read data holds when not enabled.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: hdl/vrfc_route_check.sv
// ============================================================================
// vrfc_route_check
// Check stage: tracks separators and segment lengths, issues the table read.
// ============================================================================
module vrfc_route_check #(
   parameter int MAX_NODES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             op,
   input  logic [vrfc_pkg::NODE_W-1:0]      node,
   input  logic                             last,
   input  logic [vrfc_pkg::CSR_W-1:0]       customer_count,
   input  logic [vrfc_pkg::CSR_W-1:0]       max_stops,
   input  logic                             stall,
   output logic                             rd_en,
   output logic [2*$clog2(MAX_NODES)-1:0]   rd_addr,
   output vrfc_pkg::leg_type                leg
);
   import vrfc_pkg::*;

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int EXT_W = (IDX_W > NODE_W) ? IDX_W : NODE_W;

   logic [NODE_W-1:0]  prev_node_ff, prev_node_in;
   logic               at_start_ff, at_start_in;
   logic [STOPS_W-1:0] stops_ff, stops_in;
   logic               end_bad_ff, end_bad_in;
   logic               adj_bad_ff, adj_bad_in;
   logic               over_bad_ff, over_bad_in;
   leg_type            leg_ff, leg_in;

   logic               route_acc;
   logic               node_sep;
   logic               prev_sep;
   logic [STOPS_W-1:0] stops_base;
   logic [STOPS_W:0]   stops_next;
   logic               node_oob;
   logic               prev_oob;
   logic [EXT_W-1:0]   node_x;
   logic [EXT_W-1:0]   prev_x;
   reason_type         reason;

   assign route_acc = accept && (op == OP_ROUTE_NODE);
   assign node_sep  = (node >= customer_count);
   assign prev_sep  = (prev_node_ff >= customer_count);
   assign node_oob  = (int'(node) >= MAX_NODES);
   assign prev_oob  = (int'(prev_node_ff) >= MAX_NODES);

   // Table read of the leg from the previous node to this one.
   assign node_x  = EXT_W'(node);
   assign prev_x  = EXT_W'(prev_node_ff);
   assign rd_en   = route_acc && !at_start_ff;
   assign rd_addr = {prev_x[IDX_W-1:0], node_x[IDX_W-1:0]};

   // Customer count of the current segment; a new route starts from zero.
   assign stops_base = at_start_ff ? '0 : stops_ff;
   assign stops_next = {1'b0, stops_base} + 1'b1;

   // Route state update for one accepted node.
   always_comb begin
      prev_node_in = prev_node_ff;
      at_start_in  = at_start_ff;
      stops_in     = stops_ff;
      end_bad_in   = end_bad_ff;
      adj_bad_in   = adj_bad_ff;
      over_bad_in  = over_bad_ff;
      if (route_acc) begin
         if (at_start_ff) begin
            end_bad_in  = node_sep;
            adj_bad_in  = 1'b0;
            over_bad_in = 1'b0;
         end
         if (node_sep) begin
            stops_in = '0;
            if (!at_start_ff && prev_sep) begin
               adj_bad_in = 1'b1;
            end
         end else begin
            if (stops_next > {1'b0, max_stops}) begin
               over_bad_in = 1'b1;
            end
            stops_in = stops_next[STOPS_W] ? STOPS_MAX : stops_next[STOPS_W-1:0];
         end
         if (last && node_sep) begin
            end_bad_in = 1'b1;
         end
         prev_node_in = node;
         at_start_in  = last;
      end
   end

   // Failure reason as seen after this node.
   always_comb begin
      if (end_bad_in) begin
         reason = REASON_END_SEP;
      end else if (adj_bad_in) begin
         reason = REASON_ADJ_SEP;
      end else if (over_bad_in) begin
         reason = REASON_OVERLONG;
      end else begin
         reason = REASON_NONE;
      end
   end

   // Pipeline register toward the cost stage; holds while stalled.
   always_comb begin
      leg_in = leg_ff;
      if (route_acc) begin
         leg_in.valid  = 1'b1;
         leg_in.start  = at_start_ff;
         leg_in.last   = last;
         leg_in.oob    = node_oob || prev_oob;
         leg_in.reason = reason;
      end else if (!stall) begin
         leg_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_node_ff <= '0;
         at_start_ff  <= 1'b1;
         stops_ff     <= '0;
         end_bad_ff   <= 1'b0;
         adj_bad_ff   <= 1'b0;
         over_bad_ff  <= 1'b0;
         leg_ff       <= '0;
      end else begin
         prev_node_ff <= prev_node_in;
         at_start_ff  <= at_start_in;
         stops_ff     <= stops_in;
         end_bad_ff   <= end_bad_in;
         adj_bad_ff   <= adj_bad_in;
         over_bad_ff  <= over_bad_in;
         leg_ff       <= leg_in;
      end
   end

   assign leg = leg_ff;
endmodule

// File: hdl/vrfc_cost_acc.sv
// ============================================================================
// vrfc_cost_acc
// Cost stage: saturating leg sum and the response output register.
// ============================================================================
module vrfc_cost_acc (
   input  logic                        clock,
   input  logic                        reset,
   input  vrfc_pkg::leg_type           leg,
   input  logic [vrfc_pkg::DIST_W-1:0] rd_data,
   output logic                        stall,
   vrfc_rsp_if.source                  rsp_ch
);
   import vrfc_pkg::*;

   logic [COST_W-1:0] cost_ff, cost_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              feasible_ff, feasible_in;
   reason_type        reason_ff, reason_in;
   logic [COST_W-1:0] rcost_ff, rcost_in;

   logic              advance;
   logic              emit;
   logic [DIST_W-1:0] leg_dist;
   logic [COST_W:0]   sum;
   logic [COST_W-1:0] cost_new;

   // A finished route waits here while the output register is still full.
   assign stall   = leg.valid && leg.last && rsp_valid_ff && !rsp_ch.ready;
   assign advance = leg.valid && !stall;
   assign emit    = advance && leg.last;

   // Saturating accumulate; the first node of a route starts from zero.
   assign leg_dist = leg.oob ? '0 : rd_data;
   assign sum      = {1'b0, cost_ff} + (COST_W + 1)'(leg_dist);
   assign cost_new = leg.start ? '0 : (sum[COST_W] ? '1 : sum[COST_W-1:0]);

   always_comb begin
      cost_in      = advance ? cost_new : cost_ff;
      rsp_valid_in = rsp_valid_ff;
      feasible_in  = feasible_ff;
      reason_in    = reason_ff;
      rcost_in     = rcost_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         feasible_in  = (leg.reason == REASON_NONE);
         reason_in    = leg.reason;
         rcost_in     = cost_new;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      feasible_ff <= feasible_in;
      reason_ff   <= reason_in;
      rcost_ff    <= rcost_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.feasible    = feasible_ff;
   assign rsp_ch.fail_reason = reason_ff;
   assign rsp_ch.route_cost  = rcost_ff;
endmodule

// File: hdl/vrp_route_feasibility_cost.sv
// ============================================================================
// vrp_route_feasibility_cost
// Distance table load, route feasibility check and saturating leg cost.
// ============================================================================
//
//   Channel  Direction  Transaction
//   req_ch   in         op 0 writes a distance entry, op 1 presents a route node
//   rsp_ch   out        feasible, fail_reason and route_cost of a finished route
//   csr_ch   in         register write: customer_count, vehicle_count, max_stops
//
// One request per cycle is accepted unless a stall holds it; each route node
// after the first makes one read of the distance RAM, whose registered output
// feeds the accumulator; the response leaves from a registered output.
// Reset is synchronous and clears control state; the distance RAM is not
// cleared and must be loaded before routes are presented.
// Requests stall only while a finished route waits for a full output register.
//
module vrp_route_feasibility_cost #(
   parameter int MAX_NODES = 64
) (
   input logic        clock,
   input logic        reset,
   vrfc_req_if.sink   req_ch,
   vrfc_rsp_if.source rsp_ch,
   vrfc_csr_if.sink   csr_ch
);
   import vrfc_pkg::*;

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int EXT_W  = (IDX_W > NODE_W) ? IDX_W : NODE_W;
   localparam int ADDR_W = 2 * IDX_W;

   logic [CSR_W-1:0] customer_count_ff, customer_count_in;
   logic [CSR_W-1:0] vehicle_count_ff, vehicle_count_in;
   logic [CSR_W-1:0] max_stops_ff, max_stops_in;

   logic              accept;
   logic              stall;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [DIST_W-1:0] ram_rdata;
   logic [EXT_W-1:0]  row_x;
   logic [EXT_W-1:0]  col_x;
   leg_type           leg;

   // Register writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      customer_count_in = customer_count_ff;
      vehicle_count_in  = vehicle_count_ff;
      max_stops_in      = max_stops_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_CUSTOMER_COUNT: customer_count_in = csr_ch.data;
            CSR_VEHICLE_COUNT:  vehicle_count_in  = csr_ch.data;
            CSR_MAX_STOPS:      max_stops_in      = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         customer_count_ff <= CUSTOMER_COUNT_RST;
         vehicle_count_ff  <= VEHICLE_COUNT_RST;
         max_stops_ff      <= MAX_STOPS_RST;
      end else begin
         customer_count_ff <= customer_count_in;
         vehicle_count_ff  <= vehicle_count_in;
         max_stops_ff      <= max_stops_in;
      end
   end

   // Request handshake.
   assign req_ch.ready = !stall;
   assign accept       = req_ch.valid && req_ch.ready;

   // Distance table writes; entries outside the node range are dropped.
   assign row_x     = EXT_W'(req_ch.row);
   assign col_x     = EXT_W'(req_ch.col);
   assign ram_we    = accept && (req_ch.op == OP_TABLE_WRITE)
                      && (int'(req_ch.row) < MAX_NODES) && (int'(req_ch.col) < MAX_NODES);
   assign ram_waddr = {row_x[IDX_W-1:0], col_x[IDX_W-1:0]};

   vrfc_ram #(
      .WIDTH (DIST_W),
      .DEPTH (1 << ADDR_W)
   ) u_dist_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_ch.distance),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   vrfc_route_check #(
      .MAX_NODES (MAX_NODES)
   ) u_check (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .op             (req_ch.op),
      .node           (req_ch.node),
      .last           (req_ch.last),
      .customer_count (customer_count_ff),
      .max_stops      (max_stops_ff),
      .stall          (stall),
      .rd_en          (ram_re),
      .rd_addr        (ram_raddr),
      .leg            (leg)
   );

   vrfc_cost_acc u_cost (
      .clock   (clock),
      .reset   (reset),
      .leg     (leg),
      .rd_data (ram_rdata),
      .stall   (stall),
      .rsp_ch  (rsp_ch)
   );

   // A table write and a leg read never share a cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("distance RAM written and read in the same cycle");

   // A new response follows a finished route in the cost stage.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(leg.valid && leg.last))
      else $error("response without a finished route");

   // The feasible flag agrees with the reason code.
   a_feasible_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.feasible == (rsp_ch.fail_reason == REASON_NONE)))
      else $error("feasible flag disagrees with fail reason");

   // A stalled leg is still present in the next cycle.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> leg.valid && leg.last)
      else $error("stalled route left the cost stage");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Route feasibility and cost testbench
// Loads distance entries and streams candidate routes into the block. For
// every route it predicts the verdict, the failure reason and the saturated
// leg cost. Every response is compared with the oldest pending prediction,
// under several register settings and changing back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import vrfc_pkg::*;

   localparam int TABLE_SIZE   = 64;
   localparam int PHASE_ITEMS  = 275;
   localparam int DRAIN_CYCLES = 8;
   localparam int HEAVY_NODES  = 140;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [DIST_W-1:0]    DIST_MAX  = '1;
   localparam logic [COST_W-1:0]    COST_SAT  = '1;

   typedef struct {
      logic              op;
      logic [NODE_W-1:0] row, col;
      logic [DIST_W-1:0] distance;
      logic [NODE_W-1:0] node;
      logic              last;
   } route_req_type;

   typedef struct packed {
      logic              feasible;
      reason_type        reason;
      logic [COST_W-1:0] cost;
   } verdict_type;

   logic clock;
   logic reset;

   vrfc_req_if req_if();
   vrfc_rsp_if rsp_if();
   vrfc_csr_if csr_if();

   vrp_route_feasibility_cost DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   route_req_type route_feed[$];
   verdict_type   pending_verdicts[$];
   route_req_type feed_item;
   verdict_type   oldest_verdict;
   int            mismatch_count;
   int            fed_count;
   int            taken_count;
   int            send_gap_pct;
   int            recv_stall_pct;

   // Predicted block state.
   logic [DIST_W-1:0]  dist_mem [TABLE_SIZE][TABLE_SIZE];
   logic [CSR_W-1:0]   cust_limit_q;
   logic [CSR_W-1:0]   fleet_q;
   logic [CSR_W-1:0]   stop_limit_q;
   logic [NODE_W-1:0]  last_node_q;
   logic               route_open_q;
   logic [COST_W-1:0]  cost_q;
   logic [STOPS_W-1:0] stops_q;
   logic               end_bad_q;
   logic               adj_bad_q;
   logic               long_bad_q;

   // Stimulus generator state.
   bit                written_q [TABLE_SIZE][TABLE_SIZE];
   int                cfg_cust;
   int                cfg_stops;
   logic [NODE_W-1:0] gen_prev;
   bit                gen_open;
   bit                gen_noise;
   int                phase_items;

   // Clock.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog.
   initial begin
      #3_000_000;
      $display("vrp_route_feasibility_cost: mismatch");
      $finish;
   end

   task automatic note_mismatch(input string what, input logic [COST_W-1:0] want,
                                input logic [COST_W-1:0] got);
      $display("ERROR at %0t: %s expected 0x%0h, got 0x%0h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // One customer more in the current segment; the limit check sees the
   // count before it saturates.
   task automatic count_stop();
      logic [STOPS_W:0] next;
      next = {1'b0, stops_q} + 1'b1;
      if (next > stop_limit_q) long_bad_q = 1'b1;
      stops_q = (next > STOPS_MAX) ? STOPS_MAX : next[STOPS_W-1:0];
   endtask

   // Advance the route by one node and queue the verdict when it closes.
   task automatic route_step(input logic [NODE_W-1:0] n, input logic fin);
      logic [COST_W:0] sum;
      verdict_type     v;
      if (!route_open_q) begin
         cost_q     = '0;
         stops_q    = '0;
         end_bad_q  = 1'b0;
         adj_bad_q  = 1'b0;
         long_bad_q = 1'b0;
         if (n >= cust_limit_q) end_bad_q = 1'b1;
         else count_stop();
         route_open_q = 1'b1;
      end else begin
         sum    = {1'b0, cost_q} + (COST_W + 1)'(dist_mem[last_node_q][n]);
         cost_q = sum[COST_W] ? COST_SAT : sum[COST_W-1:0];
         if (n >= cust_limit_q) begin
            if (last_node_q >= cust_limit_q) adj_bad_q = 1'b1;
            stops_q = '0;
         end else begin
            count_stop();
         end
      end
      last_node_q = n;
      if (fin) begin
         if (n >= cust_limit_q) end_bad_q = 1'b1;
         if (end_bad_q) v.reason = REASON_END_SEP;
         else if (adj_bad_q) v.reason = REASON_ADJ_SEP;
         else if (long_bad_q) v.reason = REASON_OVERLONG;
         else v.reason = REASON_NONE;
         v.feasible = (v.reason == REASON_NONE);
         v.cost     = cost_q;
         pending_verdicts = {pending_verdicts, v};
         route_open_q = 1'b0;
      end
   endtask

   // Stimulus helpers.
   function automatic logic [DIST_W-1:0] rand_dist();
      case ($urandom_range(9))
         0: return '0;
         1: return DIST_MAX;
         default: return DIST_W'($urandom);
      endcase
   endfunction

   function automatic logic [NODE_W-1:0] pick_customer();
      return NODE_W'($urandom_range(cfg_cust - 1, 0));
   endfunction

   function automatic logic [NODE_W-1:0] pick_separator();
      return NODE_W'($urandom_range(TABLE_SIZE - 1, cfg_cust));
   endfunction

   function automatic void push_table_write(input logic [NODE_W-1:0] r,
                                            input logic [NODE_W-1:0] c,
                                            input logic [DIST_W-1:0] d);
      route_req_type it;
      it.op       = OP_TABLE_WRITE;
      it.row      = r;
      it.col      = c;
      it.distance = d;
      it.node     = NODE_W'($urandom);
      it.last     = 1'($urandom);
      written_q[r][c] = 1'b1;
      route_feed = {route_feed, it};
      fed_count++;
      phase_items++;
   endfunction

   // Present a route node; the leg it closes is loaded first if needed, so
   // that no unwritten entry is ever read.
   function automatic void push_node(input logic [NODE_W-1:0] n, input logic fin);
      route_req_type it;
      if (gen_open && gen_noise && $urandom_range(11) == 0)
         push_table_write(NODE_W'($urandom), NODE_W'($urandom), rand_dist());
      if (gen_open && !written_q[gen_prev][n])
         push_table_write(gen_prev, n, rand_dist());
      it.op       = OP_ROUTE_NODE;
      it.row      = NODE_W'($urandom);
      it.col      = NODE_W'($urandom);
      it.distance = DIST_W'($urandom);
      it.node     = n;
      it.last     = fin;
      route_feed = {route_feed, it};
      fed_count++;
      phase_items++;
      gen_prev = n;
      gen_open = !fin;
   endfunction

   function automatic void gen_segment_route(input int count);
      for (int k = 0; k < count; k++) push_node(pick_customer(), k == count - 1);
   endfunction

   // Alternating legs loaded with the largest distance drive the sum into
   // saturation.
   function automatic void gen_heavy_route();
      logic [NODE_W-1:0] a, b;
      a = pick_customer();
      b = pick_customer();
      gen_noise = 1'b0;
      push_table_write(a, b, DIST_MAX);
      push_table_write(b, a, DIST_MAX);
      for (int i = 0; i < HEAVY_NODES; i++) push_node((i % 2) ? b : a, i == HEAVY_NODES - 1);
   endfunction

   // Mostly well-formed routes, some overlong segments, the rest noise.
   function automatic void gen_random_route();
      int kind, nseg, len, lim;
      kind = $urandom_range(99);
      if (kind < 75 && cfg_cust > 0 && cfg_stops > 0) begin
         nseg = $urandom_range(4, 1);
         lim  = (cfg_stops < 6) ? cfg_stops : 6;
         for (int s = 0; s < nseg; s++) begin
            if (s > 0) push_node(pick_separator(), 1'b0);
            len = $urandom_range(lim, 1);
            for (int k = 0; k < len; k++)
               push_node(pick_customer(), s == nseg - 1 && k == len - 1);
         end
      end else if (kind < 85 && cfg_cust > 0) begin
         gen_segment_route(cfg_stops + $urandom_range(3, 1));
      end else begin
         len = $urandom_range(8, 1);
         for (int k = 0; k < len; k++)
            push_node((cfg_cust == 0 || $urandom_range(1)) ? pick_separator() : pick_customer(),
                      k == len - 1);
      end
   endfunction

   function automatic void fill_random();
      gen_noise = 1'b1;
      while (phase_items < PHASE_ITEMS) begin
         if ($urandom_range(4) == 0)
            push_table_write(NODE_W'($urandom), NODE_W'($urandom), rand_dist());
         gen_random_route();
      end
   endfunction

   // Register write; the predictor takes the value once it is accepted.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_CUSTOMER_COUNT: cust_limit_q = val;
         CSR_VEHICLE_COUNT:  fleet_q      = val;
         CSR_MAX_STOPS:      stop_limit_q = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input int cust, input int fleet, input int stops);
      cfg_cust  = cust;
      cfg_stops = stops;
      write_csr(CSR_CUSTOMER_COUNT, CSR_W'(cust));
      write_csr(CSR_VEHICLE_COUNT, CSR_W'(fleet));
      write_csr(CSR_MAX_STOPS, CSR_W'(stops));
   endtask

   // Wait until every request is taken and every verdict has come back.
   task automatic drain();
      while (taken_count != fed_count || req_if.valid || pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      phase_items = 0;
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (route_feed.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            feed_item = route_feed.pop_front();
            req_if.op       <= feed_item.op;
            req_if.row      <= feed_item.row;
            req_if.col      <= feed_item.col;
            req_if.distance <= feed_item.distance;
            req_if.node     <= feed_item.node;
            req_if.last     <= feed_item.last;
            req_if.valid    <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Accepted requests update the predictor.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         taken_count++;
         if (req_if.op == OP_TABLE_WRITE) dist_mem[req_if.row][req_if.col] = req_if.distance;
         else route_step(req_if.node, req_if.last);
      end
   end

   // Response back-pressure.
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_verdicts.size() == 0) begin
            note_mismatch("response with no route pending", '0, rsp_if.route_cost);
         end else begin
            oldest_verdict = pending_verdicts.pop_front();
            if (rsp_if.feasible !== oldest_verdict.feasible)
               note_mismatch("feasible", COST_W'(oldest_verdict.feasible),
                             COST_W'(rsp_if.feasible));
            if (rsp_if.fail_reason !== oldest_verdict.reason)
               note_mismatch("fail_reason", COST_W'(oldest_verdict.reason),
                             COST_W'(rsp_if.fail_reason));
            if (rsp_if.route_cost !== oldest_verdict.cost)
               note_mismatch("route_cost", oldest_verdict.cost, rsp_if.route_cost);
         end
      end
   end

   // Test sequence.
   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.op       = OP_TABLE_WRITE;
      req_if.row      = '0;
      req_if.col      = '0;
      req_if.distance = '0;
      req_if.node     = '0;
      req_if.last     = 1'b0;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.index    = CSR_CUSTOMER_COUNT;
      csr_if.data     = '0;
      mismatch_count  = 0;
      fed_count       = 0;
      taken_count     = 0;
      phase_items     = 0;
      cust_limit_q    = CUSTOMER_COUNT_RST;
      fleet_q         = VEHICLE_COUNT_RST;
      stop_limit_q    = MAX_STOPS_RST;
      last_node_q     = '0;
      route_open_q    = 1'b0;
      cost_q          = '0;
      stops_q         = '0;
      end_bad_q       = 1'b0;
      adj_bad_q       = 1'b0;
      long_bad_q      = 1'b0;
      cfg_cust        = int'(CUSTOMER_COUNT_RST);
      cfg_stops       = int'(MAX_STOPS_RST);
      gen_prev        = '0;
      gen_open        = 1'b0;
      gen_noise       = 1'b0;
      send_gap_pct    = 14;
      recv_stall_pct  = 74;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed routes under the reset settings.
      push_table_write(6'd63, 6'd63, DIST_MAX);
      push_table_write(6'd0, 6'd63, '0);
      push_table_write(6'd63, 6'd0, 25'h0AAAAAA);
      push_table_write(6'd0, 6'd1, 25'h1555555);
      push_table_write(6'd1, 6'd0, 25'h0F0F0F0);
      // A one-node route costs nothing.
      push_node(6'd5, 1'b1);
      // A lone separator fails the end check.
      push_node(6'd63, 1'b1);
      // Two single-customer segments pass.
      push_node(6'd0, 1'b0);
      push_node(6'd63, 1'b0);
      push_node(6'd0, 1'b1);
      // Adjacent separators.
      push_node(6'd0, 1'b0);
      push_node(6'd63, 1'b0);
      push_node(6'd63, 1'b0);
      push_node(6'd0, 1'b1);
      // Route starting on a separator.
      push_node(6'd63, 1'b0);
      push_node(6'd0, 1'b1);
      // End separator outranks adjacent separators.
      push_node(6'd0, 1'b0);
      push_node(6'd63, 1'b0);
      push_node(6'd63, 1'b1);
      // A table write in the middle of a route feeds the next leg.
      push_node(6'd0, 1'b0);
      push_table_write(6'd0, 6'd1, 25'h0123456);
      push_node(6'd1, 1'b1);
      fill_random();
      drain();

      // Widest settings: segment limit at the counter's top.
      set_config(63, 32, 63);
      gen_noise = 1'b0;
      gen_segment_route(63);
      gen_segment_route(64);
      gen_segment_route(70);
      gen_heavy_route();
      fill_random();
      drain();

      send_gap_pct   = 74;
      recv_stall_pct = 14;
      set_config(1, 1, 1);
      fill_random();
      drain();

      // Every node a separator; the spare index must be ignored.
      set_config(0, 17, 5);
      write_csr(CSR_SPARE, CSR_W'($urandom));
      fill_random();
      drain();

      send_gap_pct   = 0;
      recv_stall_pct = 0;
      // No customer allowed in any segment.
      set_config($urandom_range(40, 2), $urandom_range(32, 1), 0);
      fill_random();
      drain();

      set_config($urandom_range(12, 2), $urandom_range(32, 1), $urandom_range(8, 1));
      gen_heavy_route();
      fill_random();
      drain();

      if (mismatch_count == 0) begin
         $display("vrp_route_feasibility_cost: match");
      end else begin
         $display("vrp_route_feasibility_cost: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/vrfc_pkg.sv
hdl/vrfc_ifs.sv
hdl/vrfc_ram.sv
hdl/vrfc_route_check.sv
hdl/vrfc_cost_acc.sv
hdl/vrp_route_feasibility_cost.sv
sim/testbench.sv
